// ===== design/rfc_pkg.sv =====
// Shared types and constants for the response frame checker.
// Holds the item structs of both channels, control characters, status codes
// and the hex digit decoder. Depends on nothing.
package rfc_pkg;

	// Default cap on kept bytes per response
	localparam int MAX_BYTES_DEFAULT = 255;

	// Control characters of the response frame
	localparam logic [7:0] CH_STX  = 8'h02;
	localparam logic [7:0] CH_ETX  = 8'h03;
	localparam logic [7:0] CH_ACK  = 8'h06;
	localparam logic [7:0] CH_XOFF = 8'h18;
	localparam logic [7:0] CH_XON  = 8'h1A;

	// Status codes of the final item
	localparam logic [2:0] ST_OK_CONTENT = 3'd0;
	localparam logic [2:0] ST_OK_NONE    = 3'd1;
	localparam logic [2:0] ST_NO_ACK     = 3'd2;
	localparam logic [2:0] ST_SYNTAX     = 3'd3;
	localparam logic [2:0] ST_NO_XON     = 3'd4;
	localparam logic [2:0] ST_BAD_SUM    = 3'd5;
	localparam logic [2:0] ST_FRAMING    = 3'd6;

	// Item kinds
	localparam logic KIND_CONTENT = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_chunk;
	} in_item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] content_byte;
		logic [2:0] status;
		logic [9:0] content_length;
		logic [7:0] computed_sum;
		logic [7:0] received_sum;
		logic       final_result;
	} out_item_t;

	// Up to two results caused by one accepted item, content first
	typedef struct packed {
		logic      has_content;
		logic      has_status;
		out_item_t content;
		out_item_t stat;
	} res_pair_t;

	// Hex digit decode: bit 4 flags a character that is not a hex digit
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r = {1'b0, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

// ===== design/response_frame_checker_top.sv =====
// Top level of the response frame checker: byte channel in, result channel out.
// Instantiates rfc_parser and holds the four-entry result queue.
// Depends on rfc_pkg and rfc_parser.
//
// Usage:
// - octet_* carries one received byte per item, end_of_chunk set on the
//   final byte of a response. An item is taken when octet_valid is high and
//   octet_stall is low.
// - result_* carries results: a content item (kind 0) for each payload byte,
//   and one status item (kind 1, final_result 1) per response.
// - Latency: the results of a byte are offered on the cycle after it is
//   taken at the earliest, behind any results still queued; content before
//   status.
// - Throughput: one byte per cycle while octet_stall is low. The parser updates
//   flags, counter and sum per byte; a four-entry result queue decouples the two sides.
// - The final byte may cause two results, so it may take two queue entries;
//   octet_stall rises while fewer than two entries are free.
// - When the receiver stalls, the head result holds and the queue fills;
//   bytes keep flowing until fewer than two entries are free.
// - Reset clears the parser state and empties the queue. Parser state also
//   clears after every final byte, ready for the next response.
// - Bytes past MAX_BYTES in one response are dropped and mark it framing unless it fails on ACK, XOFF or XON first.
module response_frame_checker_top #(
	parameter int MAX_BYTES = rfc_pkg::MAX_BYTES_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               octet_valid,
	output logic               octet_stall,
	input  rfc_pkg::in_item_t  octet_item,
	output logic               result_valid,
	input  logic               result_stall,
	output rfc_pkg::out_item_t result_item
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	rfc_pkg::out_item_t fifo_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	rfc_pkg::res_pair_t res;
	logic               take, pop;
	logic [1:0]         n_push;

	// Hold off new bytes unless two queue entries are free
	assign octet_stall = count_q > CNT_W'(DEPTH - 2);
	assign take        = octet_valid && !octet_stall;

	rfc_parser #(
		.MAX_BYTES(MAX_BYTES)
	) u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (take),
		.item  (octet_item),
		.res   (res)
	);

	assign result_valid = count_q != '0;
	assign result_item  = fifo_q[rd_ptr_q];
	assign pop          = result_valid && !result_stall;
	assign n_push       = take ? ({1'b0, res.has_content} + {1'b0, res.has_status}) : 2'd0;

	// Queue storage: content first, status behind it
	always_ff @(posedge clk) begin
		if (take) begin
			if (res.has_content) begin
				fifo_q[wr_ptr_q] <= res.content;
				if (res.has_status) begin
					fifo_q[wr_ptr_q + PTR_W'(1)] <= res.stat;
				end
			end else if (res.has_status) begin
				fifo_q[wr_ptr_q] <= res.stat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("result queue overfilled");

	a_final_gives_result : assert property (@(posedge clk) disable iff (!arst_n)
		take && octet_item.end_of_chunk |=> result_valid)
		else $error("final byte left no result");

	a_status_is_final : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_item.kind == result_item.final_result))
		else $error("status item and final mark disagree");

	a_content_clean : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.kind == rfc_pkg::KIND_CONTENT |->
		result_item.status == rfc_pkg::ST_OK_CONTENT &&
		result_item.content_length == '0)
		else $error("content item carries status fields");
`endif

endmodule

// ===== design/rfc_parser.sv =====
// Frame parser: per-response flags, length, sum and tail window.
// Produces the content and status results caused by one accepted item.
// Depends on rfc_pkg.
module rfc_parser #(
	parameter int MAX_BYTES = rfc_pkg::MAX_BYTES_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  rfc_pkg::in_item_t item,
	output rfc_pkg::res_pair_t res
);

	localparam int POS_W = $clog2(MAX_BYTES + 1);
	localparam int CMP_W = ((POS_W > 10) ? POS_W : 10) + 1;
	localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_BYTES);

	logic [POS_W-1:0] pos_q, pos_n;
	logic             ack_q, ack_n, xoff_q, xoff_n, xon_q, xon_n;
	logic             first_q, first_n, third_q, third_n;
	logic [9:0]       len_q, len_n;
	logic             lenbad_q, lenbad_n;
	logic [7:0]       sum_q, sum_n;
	logic [23:0]      tail_q, tail_n;
	logic             ovf_q, ovf_n;

	logic       live, len_off, digit, take_content;
	logic [7:0] b, m2, m3, m4;
	logic [9:0] len_x10;
	logic [4:0] hi, lo;
	logic [2:0] st;
	logic       sum_fields;

	always_comb begin
		b       = item.rx_byte;
		live    = pos_q < MAX_POS;
		digit   = (b >= 8'h30) && (b <= 8'h39);
		len_off = live && (pos_q >= POS_W'(3)) && (pos_q <= POS_W'(5));
		len_x10 = {len_q[6:0], 3'b000} + {len_q[8:0], 1'b0};

		ack_n    = ack_q | (live && b == rfc_pkg::CH_ACK);
		xoff_n   = xoff_q | (live && b == rfc_pkg::CH_XOFF);
		xon_n    = xon_q | (live && b == rfc_pkg::CH_XON);
		first_n  = first_q | (live && pos_q == '0 && b == rfc_pkg::CH_ACK);
		third_n  = third_q | (live && pos_q == POS_W'(2) && b == rfc_pkg::CH_STX);
		len_n    = (len_off && digit) ? len_x10 + {6'd0, b[3:0]} : len_q;
		lenbad_n = lenbad_q | (len_off && !digit);

		// Pass a byte out while its offset lies inside the decoded length, after STX and a clean length field
		take_content = live && (pos_q >= POS_W'(6)) && third_q && !lenbad_q &&
			(CMP_W'(pos_q) < CMP_W'(len_q) + CMP_W'(6));
		sum_n  = sum_q + (take_content ? b : 8'd0);
		pos_n  = live ? pos_q + POS_W'(1) : pos_q;
		tail_n = live ? {tail_q[15:0], b} : tail_q;
		ovf_n  = ovf_q | !live;

		m2 = tail_n[15:8];
		m3 = tail_n[23:16];
		m4 = ovf_n ? 8'd0 : tail_q[23:16];
		hi = rfc_pkg::hex_decode(m4);
		lo = rfc_pkg::hex_decode(m3);

		sum_fields = 1'b0;
		if (!ack_n) begin
			st = rfc_pkg::ST_NO_ACK;
		end else if (xoff_n) begin
			st = rfc_pkg::ST_SYNTAX;
		end else if (!xon_n) begin
			st = rfc_pkg::ST_NO_XON;
		end else if (ovf_n || !first_n || tail_n[7:0] != rfc_pkg::CH_XON) begin
			st = rfc_pkg::ST_FRAMING;
		end else if (third_n && m2 == rfc_pkg::CH_ETX) begin
			if (lenbad_n || pos_n < POS_W'(6)) begin
				st = rfc_pkg::ST_FRAMING;
			end else begin
				sum_fields = 1'b1;
				if (hi[4] || lo[4] || {hi[3:0], lo[3:0]} != sum_n) begin
					st = rfc_pkg::ST_BAD_SUM;
				end else begin
					st = rfc_pkg::ST_OK_CONTENT;
				end
			end
		end else begin
			st = rfc_pkg::ST_OK_NONE;
		end

		res.has_content                 = take_content;
		res.content.kind                = rfc_pkg::KIND_CONTENT;
		res.content.content_byte        = b;
		res.content.status              = rfc_pkg::ST_OK_CONTENT;
		res.content.content_length      = '0;
		res.content.computed_sum        = '0;
		res.content.received_sum        = '0;
		res.content.final_result        = 1'b0;

		res.has_status                  = item.end_of_chunk;
		res.stat.kind                   = rfc_pkg::KIND_STATUS;
		res.stat.content_byte           = '0;
		res.stat.status                 = st;
		res.stat.content_length         = sum_fields ? len_n : 10'd0;
		res.stat.computed_sum           = sum_fields ? sum_n : 8'd0;
		res.stat.received_sum           = (sum_fields && !hi[4] && !lo[4]) ?
			{hi[3:0], lo[3:0]} : 8'd0;
		res.stat.final_result           = 1'b1;
	end

	// Advance state on each item; clear it after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			ack_q    <= 1'b0;
			xoff_q   <= 1'b0;
			xon_q    <= 1'b0;
			first_q  <= 1'b0;
			third_q  <= 1'b0;
			len_q    <= '0;
			lenbad_q <= 1'b0;
			sum_q    <= '0;
			tail_q   <= '0;
			ovf_q    <= 1'b0;
		end else if (take) begin
			if (item.end_of_chunk) begin
				pos_q    <= '0;
				ack_q    <= 1'b0;
				xoff_q   <= 1'b0;
				xon_q    <= 1'b0;
				first_q  <= 1'b0;
				third_q  <= 1'b0;
				len_q    <= '0;
				lenbad_q <= 1'b0;
				sum_q    <= '0;
				tail_q   <= '0;
				ovf_q    <= 1'b0;
			end else begin
				pos_q    <= pos_n;
				ack_q    <= ack_n;
				xoff_q   <= xoff_n;
				xon_q    <= xon_n;
				first_q  <= first_n;
				third_q  <= third_n;
				len_q    <= len_n;
				lenbad_q <= lenbad_n;
				sum_q    <= sum_n;
				tail_q   <= tail_n;
				ovf_q    <= ovf_n;
			end
		end
	end

endmodule
